>>> hdl/rmad_pkg.sv
package rmad_pkg;

	// Command codes carried in tuser.
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	// Heap engine operations.
	typedef enum logic [1:0] {
		HOP_PUSH,
		HOP_POP,
		HOP_REPLACE
	} heap_op_t;

	// Request from the controller to one heap engine.
	typedef struct packed {
		logic        start;
		heap_op_t    op;
		logic [31:0] value;
	} heap_req_t;

	// Status from a heap engine back to the controller.
	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] top;
	} heap_rsp_t;

	// Heap engine sequencer states.
	typedef enum logic [2:0] {
		HS_IDLE,
		HS_UP_RD,
		HS_UP_CMP,
		HS_DN_RD,
		HS_DN_RD2,
		HS_DN_CMP,
		HS_DN_WR
	} heap_state_t;

	// Controller states.
	typedef enum logic [3:0] {
		CS_IDLE,
		CS_UPPER_PUSH,
		CS_WAIT_UPUSH,
		CS_LOWER_REPL,
		CS_WAIT_LREPL,
		CS_BALANCE,
		CS_WAIT_UPOP,
		CS_WAIT_LPUSH,
		CS_MUL,
		CS_SUM,
		CS_OUT
	} ctl_state_t;

endpackage

>>> hdl/running_median_abs_deviation_top.sv
// Channel  Direction  Handshake              Payload
// s_axis   in         s_tvalid / s_tready    tuser: command; tdata: point_value, offset_value
// m_axis   out        m_tvalid / m_tready    tdata: median_value, minimum_total, overflow_seen
//
// An insert runs up to four heap operations in series, one at a time, with the single
// read port of each heap memory.
// A query passes through the multiply and sum stages.
// arst_n clears counts, sums, median and flag; heap memories are not cleared.
// A result waits in the output register while m_tready is low; no new word
// is taken until it leaves.
module running_median_abs_deviation_top #(
	parameter int HEAP_DEPTH = 512
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // point_value [31:0], offset_value [63:32]
	input  logic         s_tuser,   // command
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata    // median_value, minimum_total, overflow_seen, zero fill
);

	import rmad_pkg::*;

	localparam int CW = $clog2(HEAP_DEPTH) + 1;

	ctl_state_t        state_q, state_d;
	heap_req_t         lreq, ureq;
	heap_rsp_t         lrsp, ursp;
	logic [CW-1:0]     lcnt, ucnt;
	logic [63:0]       lsum_q, usum_q, osum_q;
	logic [31:0]       med_q;
	logic              drop_q;
	logic [31:0]       x_q, y_q;
	logic [63:0]       ml_q, mu_q;
	logic [63:0]       tot_q;
	logic              mv_q;
	logic              take;
	logic              s_tuser_q;

	rmad_heap #(.DEPTH(HEAP_DEPTH), .IS_MAX(1'b1)) u_lower (
		.clk(clk), .arst_n(arst_n), .req(lreq), .rsp(lrsp), .count(lcnt));
	rmad_heap #(.DEPTH(HEAP_DEPTH), .IS_MAX(1'b0)) u_upper (
		.clk(clk), .arst_n(arst_n), .req(ureq), .rsp(ursp), .count(ucnt));

	assign s_tready = (state_q == CS_IDLE) && !mv_q;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			lsum_q  <= '0;
			usum_q  <= '0;
			osum_q  <= '0;
			med_q   <= '0;
			drop_q  <= 1'b0;
			mv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (m_tvalid && m_tready) begin
				mv_q <= 1'b0;
			end
			if (state_q == CS_OUT) begin
				mv_q <= 1'b1;
			end
			if (take && s_tuser == CMD_INSERT) begin
				if (ucnt >= CW'(HEAP_DEPTH)) begin
					drop_q <= 1'b1;
				end else begin
					osum_q <= osum_q + {{32{s_tdata[63]}}, s_tdata[63:32]};
				end
			end
			// Sum bookkeeping as each heap operation finishes.
			if (state_q == CS_WAIT_UPUSH && ursp.done) begin
				usum_q <= usum_q + {{32{y_q[31]}}, y_q};
			end
			if (state_q == CS_WAIT_LREPL && lrsp.done) begin
				lsum_q <= lsum_q + {{32{x_q[31]}}, x_q} - {{32{y_q[31]}}, y_q};
			end
			if (state_q == CS_WAIT_UPOP && ursp.done) begin
				usum_q <= usum_q - {{32{y_q[31]}}, y_q};
				lsum_q <= lsum_q + {{32{y_q[31]}}, y_q};
			end
			if (state_q == CS_MUL) begin
				med_q <= (lcnt == '0) ? med_q : lrsp.top;
			end
		end
	end

	// Working registers for the insert and query sequences.
	always_ff @(posedge clk) begin
		if (take) begin
			x_q <= s_tdata[31:0];
			y_q <= s_tdata[31:0];
		end
		if (state_q == CS_LOWER_REPL) begin
			// Push-pop: the old top leaves when the new value is smaller.
			if (lcnt != '0 && $signed(x_q) < $signed(lrsp.top)) begin
				y_q <= lrsp.top;
			end
		end
		if (state_q == CS_BALANCE) begin
			y_q <= ursp.top;
		end
		if (state_q == CS_MUL) begin
			ml_q <= 64'($signed(med_q) * $signed({1'b0, lcnt}));
			mu_q <= 64'($signed(med_q) * $signed({1'b0, ucnt}));
		end
		if (state_q == CS_SUM) begin
			tot_q <= ml_q - lsum_q + usum_q - mu_q + osum_q;
		end
	end

	// Sequence control.
	always_comb begin
		state_d = state_q;
		lreq    = '{start: 1'b0, op: HOP_PUSH, value: y_q};
		ureq    = '{start: 1'b0, op: HOP_PUSH, value: y_q};
		case (state_q)
			CS_IDLE: begin
				if (take) begin
					if (s_tuser == CMD_QUERY) begin
						state_d = CS_MUL;
					end else if (ucnt < CW'(HEAP_DEPTH)) begin
						state_d = ($signed(s_tdata[31:0]) > $signed(med_q)) ?
							CS_UPPER_PUSH : CS_LOWER_REPL;
					end
				end
			end
			CS_LOWER_REPL: begin
				if (lcnt != '0 && $signed(x_q) < $signed(lrsp.top)) begin
					lreq    = '{start: 1'b1, op: HOP_REPLACE, value: x_q};
					state_d = CS_WAIT_LREPL;
				end else begin
					state_d = CS_UPPER_PUSH;
				end
			end
			CS_WAIT_LREPL: begin
				if (lrsp.done) state_d = CS_UPPER_PUSH;
			end
			CS_UPPER_PUSH: begin
				ureq    = '{start: 1'b1, op: HOP_PUSH, value: y_q};
				state_d = CS_WAIT_UPUSH;
			end
			CS_WAIT_UPUSH: begin
				if (ursp.done) state_d = CS_BALANCE;
			end
			CS_BALANCE: begin
				if (lcnt < ucnt) begin
					ureq    = '{start: 1'b1, op: HOP_POP, value: y_q};
					state_d = CS_WAIT_UPOP;
				end else begin
					state_d = CS_MUL;
				end
			end
			CS_WAIT_UPOP: begin
				if (ursp.done) begin
					lreq    = '{start: 1'b1, op: HOP_PUSH, value: y_q};
					state_d = CS_WAIT_LPUSH;
				end
			end
			CS_WAIT_LPUSH: begin
				if (lrsp.done) state_d = CS_BALANCE;
			end
			CS_MUL: state_d = (s_tuser_q == CMD_QUERY) ? CS_SUM : CS_IDLE;
			CS_SUM: state_d = CS_OUT;
			CS_OUT: state_d = CS_IDLE;
			default: state_d = CS_IDLE;
		endcase
	end

	// Remember whether the word was a query.
	always_ff @(posedge clk) begin
		if (take) s_tuser_q <= s_tuser;
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = {7'd0, drop_q, tot_q, med_q};

	// A result never appears while an insert sequence is running.
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> state_q == CS_IDLE)
		else $error("result raised outside idle");
	// The heaps stay balanced while idle.
	a_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_IDLE) |-> (lcnt == ucnt || lcnt == ucnt + 1'b1))
		else $error("heap counts out of balance");
	// No word is taken while a result waits.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input taken with result pending");

endmodule

>>> hdl/rmad_ram.sv
module rmad_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/rmad_heap.sv
module rmad_heap #(
	parameter int  DEPTH  = 512,
	parameter bit  IS_MAX = 1'b1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rmad_pkg::heap_req_t req,
	output rmad_pkg::heap_rsp_t rsp,
	output logic [$clog2(DEPTH):0] count
);

	import rmad_pkg::*;

	localparam int AW = $clog2(DEPTH);

	heap_state_t       state_q, state_d;
	logic [AW:0]       count_q, count_d;
	logic [AW:0]       pos_q, pos_d;
	logic [AW:0]       kid_q, kid_d;
	logic [31:0]       val_q, val_d;
	logic [31:0]       lval_q, lval_d;
	logic [31:0]       top_q, top_d;
	logic              done_q, done_d;
	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic [31:0]       wdata, rdata;
	logic [AW:0]       parent, lkid, rkid;
	logic              wr_top;

	// Heap storage; only entries below the count are ever read.
	rmad_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// Heap order: true when a belongs above b.
	function automatic logic before_f(input logic [31:0] a, input logic [31:0] b);
		if (IS_MAX) begin
			before_f = $signed(a) > $signed(b);
		end else begin
			before_f = $signed(a) < $signed(b);
		end
	endfunction

	assign parent = (pos_q - 1'b1) >> 1;
	assign lkid   = {pos_q[AW-1:0], 1'b1};
	assign rkid   = lkid + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HS_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	// The top copy mirrors entry 0 so the controller can see it at once.
	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		kid_q  <= kid_d;
		val_q  <= val_d;
		lval_q <= lval_d;
		top_q  <= top_d;
	end

	// Sift sequencer: the moving value is held in val_q, and each level costs
	// a read, a compare and a write of the displaced entry.
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		pos_d   = pos_q;
		kid_d   = kid_q;
		val_d   = val_q;
		lval_d  = lval_q;
		top_d   = top_q;
		done_d  = 1'b0;
		we      = 1'b0;
		waddr   = pos_q[AW-1:0];
		wdata   = val_q;
		raddr   = '0;
		wr_top  = 1'b0;
		case (state_q)
			HS_IDLE: begin
				if (req.start) begin
					case (req.op)
						HOP_PUSH: begin
							val_d   = req.value;
							pos_d   = count_q;
							count_d = count_q + 1'b1;
							state_d = HS_UP_RD;
						end
						HOP_POP: begin
							// The last entry becomes the sifting value.
							count_d = count_q - 1'b1;
							pos_d   = '0;
							raddr   = AW'(count_q - 1'b1);
							state_d = HS_DN_RD;
							val_d   = 32'h0;
						end
						HOP_REPLACE: begin
							val_d   = req.value;
							pos_d   = '0;
							state_d = HS_DN_RD2;
						end
						default: state_d = HS_IDLE;
					endcase
				end
			end
			HS_UP_RD: begin
				if (pos_q == '0) begin
					we      = 1'b1;
					wr_top  = 1'b1;
					state_d = HS_IDLE;
					done_d  = 1'b1;
				end else begin
					raddr   = AW'(parent);
					state_d = HS_UP_CMP;
				end
			end
			HS_UP_CMP: begin
				we = 1'b1;
				if (before_f(val_q, rdata)) begin
					// Parent moves down; continue one level up.
					wdata   = rdata;
					pos_d   = parent;
					state_d = HS_UP_RD;
				end else begin
					state_d = HS_IDLE;
					done_d  = 1'b1;
				end
			end
			HS_DN_RD: begin
				// Last entry arrives from memory.
				val_d = rdata;
				if (count_q == '0) begin
					state_d = HS_IDLE;
					done_d  = 1'b1;
				end else begin
					state_d = HS_DN_RD2;
				end
			end
			HS_DN_RD2: begin
				if (lkid < count_q) begin
					raddr   = AW'(lkid);
					state_d = HS_DN_CMP;
				end else begin
					we      = 1'b1;
					wr_top  = (pos_q == '0);
					state_d = HS_IDLE;
					done_d  = 1'b1;
				end
			end
			HS_DN_CMP: begin
				// Left child in rdata; fetch the right one if present.
				lval_d = rdata;
				kid_d  = lkid;
				if (rkid < count_q) begin
					raddr   = AW'(rkid);
					state_d = HS_DN_WR;
				end else if (before_f(rdata, val_q)) begin
					we      = 1'b1;
					wdata   = rdata;
					wr_top  = (pos_q == '0);
					pos_d   = lkid;
					state_d = HS_DN_RD2;
				end else begin
					we      = 1'b1;
					wr_top  = (pos_q == '0);
					state_d = HS_IDLE;
					done_d  = 1'b1;
				end
			end
			HS_DN_WR: begin
				we     = 1'b1;
				wr_top = (pos_q == '0);
				if (before_f(rdata, lval_q) && before_f(rdata, val_q)) begin
					wdata   = rdata;
					pos_d   = rkid;
					state_d = HS_DN_RD2;
				end else if (before_f(lval_q, val_q)) begin
					wdata   = lval_q;
					pos_d   = kid_q;
					state_d = HS_DN_RD2;
				end else begin
					state_d = HS_IDLE;
					done_d  = 1'b1;
				end
			end
			default: state_d = HS_IDLE;
		endcase
		if (we && wr_top) begin
			top_d = wdata;
		end
	end

	assign rsp.busy = (state_q != HS_IDLE);
	assign rsp.done = done_q;
	assign rsp.top  = top_q;
	assign count    = count_q;

endmodule
